[sv/ckcm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckcm_pkg
// Shared constants, codes and types for the coordinate keyed cell map.
// ----------------------------------------------------------------------------
package ckcm_pkg;

	// map capacity and derived widths
	localparam int ENTRIES = 32;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int COORD_W = 8;
	localparam int BYTE_W  = 8;
	localparam int KEY_W   = 2 * COORD_W;
	localparam int REC_W   = 2 * BYTE_W;
	localparam int STAT_W  = 3;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);

	// request opcodes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_UPDATED  = 3'd0,
		ST_APPENDED = 3'd1,
		ST_FULL     = 3'd2,
		ST_HIT      = 3'd3,
		ST_MISS     = 3'd4
	} status_t;

	// search controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_RDREC,
		S_DONE
	} state_t;

	// access request from the controller to the entry store
	typedef struct packed {
		logic             key_we;
		logic             rec_we;
		logic [IDX_W-1:0] wr_addr;
		logic [KEY_W-1:0] key_wdata;
		logic [REC_W-1:0] rec_wdata;
		logic [IDX_W-1:0] key_raddr;
		logic [IDX_W-1:0] rec_raddr;
	} mem_req_t;

	// one finished result word
	typedef struct packed {
		status_t           status;
		logic [BYTE_W-1:0] walls;
		logic [BYTE_W-1:0] visits;
	} result_t;

endpackage

[sv/ckcm_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckcm_store
// Key and record memories, one write port and one registered read port each.
// ----------------------------------------------------------------------------
module ckcm_store (
	input  logic                          clk,
	input  ckcm_pkg::mem_req_t            req,
	output logic [ckcm_pkg::KEY_W-1:0]    key_rd_data,
	output logic [ckcm_pkg::REC_W-1:0]    rec_rd_data
);

	logic [ckcm_pkg::KEY_W-1:0] key_mem [ckcm_pkg::ENTRIES];
	logic [ckcm_pkg::REC_W-1:0] rec_mem [ckcm_pkg::ENTRIES];
	logic [ckcm_pkg::KEY_W-1:0] key_rd_q;
	logic [ckcm_pkg::REC_W-1:0] rec_rd_q;

	// key memory
	always_ff @(posedge clk) begin
		if (req.key_we) begin
			key_mem[req.wr_addr] <= req.key_wdata;
		end
		key_rd_q <= key_mem[req.key_raddr];
	end

	// record memory
	always_ff @(posedge clk) begin
		if (req.rec_we) begin
			rec_mem[req.wr_addr] <= req.rec_wdata;
		end
		rec_rd_q <= rec_mem[req.rec_raddr];
	end

	assign key_rd_data = key_rd_q;
	assign rec_rd_data = rec_rd_q;

endmodule

[sv/ckcm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckcm_ctrl
// Linear search sequencer: scans filled keys one per cycle, then updates,
// appends or reads back a record and holds the result until taken.
// ----------------------------------------------------------------------------
module ckcm_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [ckcm_pkg::KEY_W-1:0]    key,
	input  logic [ckcm_pkg::REC_W-1:0]    rec,
	output logic                          res_valid,
	input  logic                          res_ready,
	output ckcm_pkg::result_t             res,
	output ckcm_pkg::mem_req_t            req,
	input  logic [ckcm_pkg::KEY_W-1:0]    key_rd_data,
	input  logic [ckcm_pkg::REC_W-1:0]    rec_rd_data
);

	ckcm_pkg::state_t            state_q, state_d;
	logic [ckcm_pkg::IDX_W-1:0]  idx_q, idx_d;
	logic [ckcm_pkg::CNT_W-1:0]  count_q, count_d;
	logic                        op_q;
	logic [ckcm_pkg::KEY_W-1:0]  key_q;
	logic [ckcm_pkg::REC_W-1:0]  rec_q;
	ckcm_pkg::result_t           res_q, res_d;
	logic [ckcm_pkg::CNT_W-1:0]  idx_ext;
	logic                        hit;
	logic                        last;

	// compare of the key read for the current index
	assign idx_ext = ckcm_pkg::CNT_W'(idx_q);
	assign hit     = (idx_ext < count_q) && (key_rd_data == key_q);
	assign last    = (idx_ext + 1'b1) >= count_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ckcm_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// request word and datapath registers
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		res_q <= res_d;
		if (in_valid && in_ready) begin
			op_q  <= op;
			key_q <= key;
			rec_q <= rec;
		end
	end

	// next state, memory requests and result
	always_comb begin
		state_d       = state_q;
		idx_d         = idx_q;
		count_d       = count_q;
		res_d         = res_q;
		in_ready      = 1'b0;
		res_valid     = 1'b0;
		req.key_we    = 1'b0;
		req.rec_we    = 1'b0;
		req.wr_addr   = idx_q;
		req.key_wdata = key_q;
		req.rec_wdata = rec_q;
		req.key_raddr = idx_q + 1'b1;
		req.rec_raddr = idx_q;
		case (state_q)
			ckcm_pkg::S_IDLE: begin
				in_ready      = 1'b1;
				req.key_raddr = '0;
				idx_d         = '0;
				if (in_valid) begin
					state_d = ckcm_pkg::S_SEARCH;
				end
			end
			ckcm_pkg::S_SEARCH: begin
				res_d.walls  = '0;
				res_d.visits = '0;
				if (hit) begin
					if (op_q == ckcm_pkg::OP_INSERT) begin
						// overwrite the record of the matching entry
						req.rec_we   = 1'b1;
						res_d.status = ckcm_pkg::ST_UPDATED;
						state_d      = ckcm_pkg::S_DONE;
					end else begin
						// record read issued at idx_q this cycle
						state_d = ckcm_pkg::S_RDREC;
					end
				end else if (last) begin
					state_d = ckcm_pkg::S_DONE;
					if (op_q == ckcm_pkg::OP_LOOKUP) begin
						res_d.status = ckcm_pkg::ST_MISS;
					end else if (count_q < ckcm_pkg::CNT_FULL) begin
						// append at the first free entry
						req.key_we   = 1'b1;
						req.rec_we   = 1'b1;
						req.wr_addr  = count_q[ckcm_pkg::IDX_W-1:0];
						count_d      = count_q + 1'b1;
						res_d.status = ckcm_pkg::ST_APPENDED;
					end else begin
						res_d.status = ckcm_pkg::ST_FULL;
					end
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ckcm_pkg::S_RDREC: begin
				res_d.status = ckcm_pkg::ST_HIT;
				res_d.walls  = rec_rd_data[ckcm_pkg::BYTE_W-1:0];
				res_d.visits = rec_rd_data[ckcm_pkg::REC_W-1:ckcm_pkg::BYTE_W];
				state_d      = ckcm_pkg::S_DONE;
			end
			ckcm_pkg::S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ckcm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ckcm_pkg::S_IDLE;
			end
		endcase
	end

	assign res = res_q;

endmodule

[sv/coordinate_keyed_cell_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coordinate_keyed_cell_map
// Small map of maze cell records keyed by an offset x,y coordinate pair.
// ----------------------------------------------------------------------------
// Usage:
//   Input word (in_valid/in_ready): opcode, key_x, key_y, walls_in, visits_in.
//   opcode 0 updates a matching record or appends a new entry (status 0, 1,
//   or 2 when the map is full); opcode 1 looks a key up (status 3 hit with
//   the stored bytes, status 4 miss with zero bytes).
//   Result word (out_valid/out_ready): status, walls_out, visits_out.
//   cfg_wr_en/cfg_wr_data set the coordinate offset, added to both key
//   coordinates modulo 256; write it only while the map is idle.
//   One word is processed at a time. The search reads one stored key per
//   cycle from the key memory and stops at the first match; a lookup hit
//   then reads the stored record, and the result is held until taken.
//   The next word is taken only once the result has been handed over.
//   Reset clears the offset and the entry count; memories are not cleared.
//   A stalled receiver holds the result in the output register while the
//   next word is searched; that word then waits until the register frees.
// ----------------------------------------------------------------------------
module coordinate_keyed_cell_map (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               opcode,
	input  logic [ckcm_pkg::COORD_W-1:0]       key_x,
	input  logic [ckcm_pkg::COORD_W-1:0]       key_y,
	input  logic [ckcm_pkg::BYTE_W-1:0]        walls_in,
	input  logic [ckcm_pkg::BYTE_W-1:0]        visits_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ckcm_pkg::STAT_W-1:0]        status,
	output logic [ckcm_pkg::BYTE_W-1:0]        walls_out,
	output logic [ckcm_pkg::BYTE_W-1:0]        visits_out,
	input  logic                               cfg_wr_en,
	input  logic [ckcm_pkg::COORD_W-1:0]       cfg_wr_data
);

	logic [ckcm_pkg::COORD_W-1:0] offset_q;
	logic [ckcm_pkg::COORD_W-1:0] kx_off;
	logic [ckcm_pkg::COORD_W-1:0] ky_off;
	logic [ckcm_pkg::KEY_W-1:0]   key;
	logic [ckcm_pkg::REC_W-1:0]   rec;
	logic                         res_valid;
	logic                         res_ready;
	ckcm_pkg::result_t            res;
	ckcm_pkg::result_t            out_q;
	logic                         out_valid_q;
	ckcm_pkg::mem_req_t           req;
	logic [ckcm_pkg::KEY_W-1:0]   key_rd_data;
	logic [ckcm_pkg::REC_W-1:0]   rec_rd_data;

	// offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_wr_en) begin
			offset_q <= cfg_wr_data;
		end
	end

	// key and record packing, offset wraps modulo 256
	assign kx_off = key_x + offset_q;
	assign ky_off = key_y + offset_q;
	assign key    = {ky_off, kx_off};
	assign rec    = {visits_in, walls_in};

	ckcm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (opcode),
		.key         (key),
		.rec         (rec),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.req         (req),
		.key_rd_data (key_rd_data),
		.rec_rd_data (rec_rd_data)
	);

	ckcm_store u_store (
		.clk         (clk),
		.req         (req),
		.key_rd_data (key_rd_data),
		.rec_rd_data (rec_rd_data)
	);

	// output register
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_q.status;
	assign walls_out  = out_q.walls;
	assign visits_out = out_q.visits;

endmodule

[sv/ckcm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckcm_checker
// Port level checks for the coordinate keyed cell map, bound to the top.
// ----------------------------------------------------------------------------
module ckcm_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [ckcm_pkg::STAT_W-1:0]        status,
	input logic [ckcm_pkg::BYTE_W-1:0]        walls_out,
	input logic [ckcm_pkg::BYTE_W-1:0]        visits_out
);

	// a stalled result word stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
	else $error("result word withdrawn before taken");

	// status stays within the defined codes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ckcm_pkg::ST_UPDATED || status == ckcm_pkg::ST_APPENDED ||
			status == ckcm_pkg::ST_FULL || status == ckcm_pkg::ST_HIT ||
			status == ckcm_pkg::ST_MISS))
	else $error("undefined status code");

	// record bytes are zero unless a lookup hit
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ckcm_pkg::ST_HIT) |-> (walls_out == '0) && (visits_out == '0))
	else $error("nonzero record bytes without lookup hit");

	// one word in flight: no accept on the cycle right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
	else $error("input taken while a word is in flight");

endmodule

bind coordinate_keyed_cell_map ckcm_checker u_ckcm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.walls_out  (walls_out),
	.visits_out (visits_out)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the coordinate keyed cell map. A directed table
// covers the empty map, appends, updates, extreme keys and the offset
// wrapping both ways. Randomized phases then mix lookups and inserts on
// stored keys, fresh keys and corner keys under several offsets, filling
// the map until inserts are dropped. Both handshakes idle at random, and a
// built-in model predicts each result word not fixed by the directed table.
// ----------------------------------------------------------------------------
module tb_top;
	import ckcm_pkg::*;

	localparam int RESET_CYCLES  = 8;
	localparam int PHASES        = 5;
	localparam int PHASE_WORDS   = 150;
	localparam int RX_HOLD_LEN   = 400;
	localparam int DRAIN_CYCLES  = 2 * (ENTRIES + 4);
	localparam int CYCLE_LIMIT   = 300000;
	localparam int PRINT_CAP     = 40;

	// directed table rows: a request word or an offset write
	typedef enum logic {
		ROW_WORD,
		ROW_OFS
	} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic              op;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [BYTE_W-1:0]  walls;
		logic [BYTE_W-1:0]  visits;
		logic              fixed;
		result_t           res;
	} row_t;

	localparam int DIR_ROWS = 21;

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic                in_ready;
	logic                opcode      = OP_INSERT;
	logic [COORD_W-1:0]  key_x       = '0;
	logic [COORD_W-1:0]  key_y       = '0;
	logic [BYTE_W-1:0]   walls_in    = '0;
	logic [BYTE_W-1:0]   visits_in   = '0;
	logic                out_valid;
	logic                out_ready   = 1'b0;
	logic [STAT_W-1:0]   status;
	logic [BYTE_W-1:0]   walls_out;
	logic [BYTE_W-1:0]   visits_out;
	logic                cfg_wr_en   = 1'b0;
	logic [COORD_W-1:0]  cfg_wr_data = '0;

	// word carries a hand-written expectation instead of the prediction
	logic                fixed_q     = 1'b0;
	result_t             fixed_res   = '{ST_UPDATED, 8'h00, 8'h00};

	// model of the map contents
	logic [KEY_W-1:0]    cell_keys [ENTRIES];
	logic [REC_W-1:0]    cell_recs [ENTRIES];
	int                  cell_count  = 0;
	logic [COORD_W-1:0]  coord_ofs   = '0;

	result_t             pending [$];
	int                  words_sent    = 0;
	int                  results_seen  = 0;
	int                  mismatches    = 0;
	int                  status_tally [5] = '{0, 0, 0, 0, 0};
	int                  offset_writes = 0;
	int                  rx_holds      = 0;
	int                  cycle_count   = 0;
	logic [COORD_W-1:0]  cur_ofs       = '0;
	bit                  sender_fast   = 1'b0;
	bit                  rx_hold_req   = 1'b0;

	row_t dir_table [DIR_ROWS] = '{
		// empty map, appends, hits, misses and updates at offset zero
		'{ROW_WORD, OP_LOOKUP, 8'h00, 8'h00, 8'h5a, 8'ha5, 1'b1, '{ST_MISS, 8'h00, 8'h00}},
		'{ROW_WORD, OP_INSERT, 8'h00, 8'h00, 8'hff, 8'hff, 1'b1, '{ST_APPENDED, 8'h00, 8'h00}},
		'{ROW_WORD, OP_LOOKUP, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, '{ST_HIT, 8'hff, 8'hff}},
		'{ROW_WORD, OP_INSERT, 8'hff, 8'hff, 8'h00, 8'h00, 1'b1, '{ST_APPENDED, 8'h00, 8'h00}},
		'{ROW_WORD, OP_LOOKUP, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, '{ST_HIT, 8'h00, 8'h00}},
		'{ROW_WORD, OP_INSERT, 8'h00, 8'h00, 8'ha5, 8'h5a, 1'b1, '{ST_UPDATED, 8'h00, 8'h00}},
		'{ROW_WORD, OP_LOOKUP, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, '{ST_HIT, 8'ha5, 8'h5a}},
		'{ROW_WORD, OP_INSERT, 8'hff, 8'h00, 8'h01, 8'h80, 1'b1, '{ST_APPENDED, 8'h00, 8'h00}},
		'{ROW_WORD, OP_LOOKUP, 8'h00, 8'hff, 8'h00, 8'h00, 1'b1, '{ST_MISS, 8'h00, 8'h00}},
		'{ROW_WORD, OP_LOOKUP, 8'hff, 8'h00, 8'h00, 8'h00, 1'b1, '{ST_HIT, 8'h01, 8'h80}},
		'{ROW_WORD, OP_INSERT, 8'hff, 8'h00, 8'h7e, 8'h81, 1'b1, '{ST_UPDATED, 8'h00, 8'h00}},
		// offset wraps forward: old keys are reached from shifted coordinates
		'{ROW_OFS,  OP_INSERT, 8'hff, 8'h00, 8'h00, 8'h00, 1'b0, '{ST_UPDATED, 8'h00, 8'h00}},
		'{ROW_WORD, OP_LOOKUP, 8'h01, 8'h01, 8'h00, 8'h00, 1'b0, '{ST_UPDATED, 8'h00, 8'h00}},
		'{ROW_WORD, OP_LOOKUP, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '{ST_UPDATED, 8'h00, 8'h00}},
		'{ROW_WORD, OP_INSERT, 8'h00, 8'h01, 8'h3c, 8'hc3, 1'b0, '{ST_UPDATED, 8'h00, 8'h00}},
		'{ROW_WORD, OP_INSERT, 8'h80, 8'h7f, 8'h55, 8'haa, 1'b0, '{ST_UPDATED, 8'h00, 8'h00}},
		'{ROW_WORD, OP_LOOKUP, 8'h80, 8'h7f, 8'h00, 8'h00, 1'b0, '{ST_UPDATED, 8'h00, 8'h00}},
		// back to zero: keys keep the offset they were stored with
		'{ROW_OFS,  OP_INSERT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '{ST_UPDATED, 8'h00, 8'h00}},
		'{ROW_WORD, OP_LOOKUP, 8'h7f, 8'h7e, 8'h00, 8'h00, 1'b0, '{ST_UPDATED, 8'h00, 8'h00}},
		'{ROW_WORD, OP_LOOKUP, 8'h80, 8'h7f, 8'h00, 8'h00, 1'b0, '{ST_UPDATED, 8'h00, 8'h00}},
		'{ROW_WORD, OP_LOOKUP, 8'hff, 8'h00, 8'h00, 8'h00, 1'b0, '{ST_UPDATED, 8'h00, 8'h00}}
	};

	coordinate_keyed_cell_map dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.key_x      (key_x),
		.key_y      (key_y),
		.walls_in   (walls_in),
		.visits_in  (visits_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.walls_out  (walls_out),
		.visits_out (visits_out),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// expected outcome of one word, updating the map model
	function automatic result_t predict_cell(input logic op, input logic [COORD_W-1:0] kx,
			input logic [COORD_W-1:0] ky, input logic [BYTE_W-1:0] walls,
			input logic [BYTE_W-1:0] visits);
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic [KEY_W-1:0]   key;
		int                 slot;
		result_t            r;
		sx   = kx + coord_ofs;
		sy   = ky + coord_ofs;
		key  = {sy, sx};
		slot = -1;
		r    = '{ST_MISS, 8'h00, 8'h00};
		// first match, lowest index first
		for (int i = 0; i < cell_count && slot < 0; i++) begin
			if (cell_keys[i] == key)
				slot = i;
		end
		if (op == OP_INSERT) begin
			if (slot >= 0) begin
				cell_recs[slot] = {visits, walls};
				r.status = ST_UPDATED;
			end else if (cell_count < ENTRIES) begin
				cell_keys[cell_count] = key;
				cell_recs[cell_count] = {visits, walls};
				cell_count++;
				r.status = ST_APPENDED;
			end else begin
				r.status = ST_FULL;
			end
		end else if (slot >= 0) begin
			r.status = ST_HIT;
			r.walls  = cell_recs[slot][BYTE_W-1:0];
			r.visits = cell_recs[slot][REC_W-1:BYTE_W];
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch at %0t, result %0d: %s is 0x%0h, expected 0x%0h",
				$time, results_seen, what, got, want);
	endtask

	// offer one word after a random gap unless sending fast, return at its acceptance edge
	task automatic send_word(input logic op, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [BYTE_W-1:0] walls,
			input logic [BYTE_W-1:0] visits, input logic fixed, input result_t res);
		int gap;
		gap = sender_fast ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		key_x     <= x;
		key_y     <= y;
		walls_in  <= walls;
		visits_in <= visits;
		fixed_q   <= fixed;
		fixed_res <= res;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	// drain the map, then write the offset while it is idle
	task automatic write_offset(input logic [COORD_W-1:0] ofs);
		in_valid <= 1'b0;
		do @(posedge clk); while (results_seen != words_sent);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= ofs;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_ofs = ofs;
		offset_writes++;
	endtask

	// request side
	initial begin : stimulus
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [KEY_W-1:0]   k;
		logic [COORD_W-1:0] ofs_plan [PHASES];
		int                 pick;
		result_t            none;
		none     = '{ST_UPDATED, 8'h00, 8'h00};
		ofs_plan = '{8'($urandom), 8'hff, 8'($urandom), 8'h00, 8'($urandom)};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_table[i].kind == ROW_OFS)
				write_offset(dir_table[i].x);
			else
				send_word(dir_table[i].op, dir_table[i].x, dir_table[i].y,
					dir_table[i].walls, dir_table[i].visits, dir_table[i].fixed,
					dir_table[i].res);
		end

		// random phases, one offset each
		for (int p = 0; p < PHASES; p++) begin
			write_offset(ofs_plan[p]);
			if (p == 1)
				rx_hold_req = 1'b1;
			for (int i = 0; i < PHASE_WORDS; i++) begin
				sender_fast = (p == 1 && i < 40) || (i >= 100 && i < 125);
				// sender pause until every result is back
				if (p == 3 && i == 70) begin
					in_valid <= 1'b0;
					do @(posedge clk); while (results_seen != words_sent);
				end
				pick = $urandom_range(0, 99);
				if (pick < 50 && cell_count != 0) begin
					// a stored key, seen through the current offset
					k = cell_keys[$urandom_range(0, cell_count - 1)];
					x = k[COORD_W-1:0] - cur_ofs;
					y = k[KEY_W-1:COORD_W] - cur_ofs;
				end else if (pick < 80) begin
					x = 8'($urandom);
					y = 8'($urandom);
				end else begin
					// corner keys near both ends of the range
					x = 8'($urandom_range(0, 3));
					y = 8'($urandom_range(0, 3));
					if ($urandom_range(0, 1))
						x = ~x;
					if ($urandom_range(0, 1))
						y = ~y;
				end
				send_word(1'($urandom_range(0, 1)), x, y, 8'($urandom), 8'($urandom),
					1'b0, none);
			end
		end

		// wait out the last results
		in_valid <= 1'b0;
		do @(posedge clk); while (results_seen != words_sent);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending.size() != 0)
			report_mismatch("results never delivered", pending.size(), 0);
		$display("covered %0d words, %0d offset writes, %0d long holds, %0d results in %0d cycles",
			words_sent, offset_writes, rx_holds, results_seen, cycle_count);
		$display("outcomes: %0d appended, %0d updated, %0d dropped full, %0d hits, %0d misses",
			status_tally[ST_APPENDED], status_tally[ST_UPDATED], status_tally[ST_FULL],
			status_tally[ST_HIT], status_tally[ST_MISS]);
		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// result side: random stalls, no-stall stretches and one long hold
	initial begin : receiver
		int stall;
		int fast_left;
		fast_left = 0;
		forever begin
			stall = 0;
			if (rx_hold_req) begin
				out_ready <= 1'b0;
				repeat (RX_HOLD_LEN) @(posedge clk);
				rx_hold_req = 1'b0;
				rx_holds++;
			end else if (fast_left > 0) begin
				fast_left--;
			end else begin
				stall = $urandom_range(0, 9);
				if ($urandom_range(0, 19) == 0)
					fast_left = 25;
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// prediction on accepted words, comparison on accepted results
	always @(posedge clk) begin : scoreboard
		result_t want;
		if (cfg_wr_en)
			coord_ofs = cfg_wr_data;
		if (in_valid && in_ready) begin
			want = predict_cell(opcode, key_x, key_y, walls_in, visits_in);
			if (fixed_q)
				want = fixed_res;
			pending.push_back(want);
			status_tally[int'(want.status)]++;
		end
		if (out_valid && out_ready) begin
			results_seen++;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result, status", int'(status), 0);
			end else begin
				want = pending.pop_front();
				if (status !== want.status)
					report_mismatch("status", int'(status), int'(want.status));
				if (walls_out !== want.walls)
					report_mismatch("walls_out", int'(walls_out), int'(want.walls));
				if (visits_out !== want.visits)
					report_mismatch("visits_out", int'(visits_out), int'(want.visits));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, words_sent - results_seen);
			$display("tb_top NOT OK");
			$finish;
		end
	end

endmodule

[files.f]
sv/ckcm_pkg.sv
sv/ckcm_store.sv
sv/ckcm_ctrl.sv
sv/coordinate_keyed_cell_map.sv
sv/ckcm_checker.sv
tb/sv/tb_top.sv
